// ----- rtl/positional_list_insert_delete_find_assert.svh -----
// Assertion macros shared by the checker files of the positional list block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef POSITIONAL_LIST_INSERT_DELETE_FIND_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_FIND_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PLID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PLID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/plid_pkg.sv -----
// Package for the positional list block: sizes, operation and status codes,
// and the sequencer state type. Depends on nothing.
`default_nettype none

package plid_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 3;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_RANGE    = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_CHK,
      S_DEL_WR,
      S_FIND_RD,
      S_FIND_CMP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/plid_req_if.sv -----
// Request channel of the positional list block: valid/ready plus one operation.
// Depends on plid_pkg for the field widths.
`default_nettype none

interface plid_req_if;
   import plid_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink   (input valid, input operation, input position, input value,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/plid_rsp_if.sv -----
// Response channel of the positional list block: valid/ready plus one result.
// Depends on plid_pkg for the field widths.
`default_nettype none

interface plid_rsp_if;
   import plid_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ADDR_W-1:0] found_position;
   logic [CNT_W-1:0]  element_count;
   logic              is_empty;

   modport source (output valid, output status, output found_position,
                   output element_count, output is_empty, input ready);
   modport sink   (input valid, input status, input found_position,
                   input element_count, input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/positional_list_insert_delete_find.sv -----
// Throughput: one operation at a time; one memory read and write port does every move.
// The next request is taken once the previous result transfer has completed.
// Reset (synchronous, active high) empties the list and clears the sequencer and
// the result valid; the element memory is not cleared and needs no sweep.
`default_nettype none

module positional_list_insert_delete_find
   import plid_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   plid_req_if.sink     req_if,
   plid_rsp_if.source   rsp_if
);

   // The list lives in a single-port-write, single-port-read memory. Only the
   // entries below the element count are ever read, so no valid bits are kept.
   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // Sequencer state and the position walker shared by all three loops.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Request fields captured at the transfer; payload, so no reset.
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;

   // Result register, which decouples the sequencer from the consumer.
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_where_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_empty_ff;

   // Memory port controls driven by the sequencer.
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Completion of one operation and what its result carries.
   logic              done;
   status_type        done_status;
   logic [ADDR_W-1:0] done_where;

   logic              req_xfer;
   logic [CNT_W-1:0]  idx_dec;
   logic [CNT_W-1:0]  idx_inc;
   op_type            req_op;

   // A new request is taken only when the sequencer is idle and the previous
   // result has already left the result register.
   assign req_if.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign req_op       = op_type'(req_if.operation);

   // The shared decrementer and incrementer that walk the list.
   assign idx_dec = idx_ff - CNT_W'(1);
   assign idx_inc = idx_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr   = '0;
      done        = 1'b0;
      done_status = ST_OK;
      done_where  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_op)
                  OP_INSERT: begin
                     // A full list is reported before a bad position.
                     if (count_ff == CAP_COUNT) begin
                        done        = 1'b1;
                        done_status = ST_FULL;
                     end else if (req_if.position > count_ff) begin
                        done        = 1'b1;
                        done_status = ST_RANGE;
                     end else if (req_if.position == count_ff) begin
                        // Appending needs no shift.
                        state_in = S_INS_PUT;
                     end else begin
                        // Shift from the top down to make room at the position.
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_DELETE: begin
                     // This also rejects every delete on an empty list.
                     if (req_if.position >= count_ff) begin
                        done        = 1'b1;
                        done_status = ST_RANGE;
                     end else begin
                        idx_in   = req_if.position + CNT_W'(1);
                        state_in = S_DEL_CHK;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_FIND_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         // Insert: move entry idx-1 up to idx, one entry per read/write pair.
         S_INS_RD: begin
            mem_raddr = idx_dec[ADDR_W-1:0];
            state_in  = S_INS_WR;
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0];
            mem_wdata = rd_data_ff;
            idx_in    = idx_dec;
            state_in  = (idx_dec == pos_ff) ? S_INS_PUT : S_INS_RD;
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_wdata = val_ff;
            count_in  = count_ff + CNT_W'(1);
            done      = 1'b1;
            state_in  = S_IDLE;
         end

         // Delete: move entry idx down to idx-1 until the end of the list.
         S_DEL_CHK: begin
            if (idx_ff < count_ff) begin
               mem_raddr = idx_ff[ADDR_W-1:0];
               state_in  = S_DEL_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_dec[ADDR_W-1:0];
            mem_wdata = rd_data_ff;
            idx_in    = idx_inc;
            state_in  = S_DEL_CHK;
         end

         // Find: read each held entry in turn and compare it with the key.
         S_FIND_RD: begin
            mem_raddr = idx_ff[ADDR_W-1:0];
            state_in  = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (rd_data_ff == val_ff) begin
               done       = 1'b1;
               done_where = idx_ff[ADDR_W-1:0];
               state_in   = S_IDLE;
            end else if (idx_inc < count_ff) begin
               idx_in   = idx_inc;
               state_in = S_FIND_RD;
            end else begin
               done        = 1'b1;
               done_status = ST_NOTFOUND;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer and list length.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pos_ff <= req_if.position;
         val_ff <= req_if.value;
      end
   end

   // Element memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // Result register. The count shown is the one left by the operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= done_status;
         rsp_where_ff  <= done_where;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.found_position = rsp_where_ff;
   assign rsp_if.element_count  = rsp_count_ff;
   assign rsp_if.is_empty       = rsp_empty_ff;

endmodule

`default_nettype wire

// ----- rtl/plid_checker.sv -----
// Port-level checker for the positional list block, bound to the top level.
// Depends on plid_pkg and the assertion macro header.
`default_nettype none

`include "positional_list_insert_delete_find_assert.svh"

module plid_checker
   import plid_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire [STAT_W-1:0]       rsp_status,
   input wire [ADDR_W-1:0]       rsp_found_position,
   input wire [CNT_W-1:0]        rsp_element_count,
   input wire                    rsp_is_empty
);

   // A result that is not taken keeps its valid and its contents.
   `PLID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_found_position) && $stable(rsp_element_count),
      "response changed while stalled")

   // The empty flag agrees with the element count.
   `PLID_ASSERT_NOW(a_empty_flag, clock, reset, rsp_valid,
      rsp_is_empty == (rsp_element_count == '0), "is_empty disagrees with count")

   // The list never grows past its capacity.
   `PLID_ASSERT_NOW(a_count_cap, clock, reset, rsp_valid,
      rsp_element_count <= CAP_COUNT, "element count above capacity")

   // A nonzero position is only reported by a successful find.
   `PLID_ASSERT_NOW(a_where_ok, clock, reset, rsp_valid && (rsp_found_position != '0),
      rsp_status == ST_OK, "found position on a failed operation")

   // One operation at a time: a request transfer is never followed at once by another.
   `PLID_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready, "request taken while busy")

endmodule

bind positional_list_insert_delete_find plid_checker u_plid_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_found_position (rsp_if.found_position),
   .rsp_element_count  (rsp_if.element_count),
   .rsp_is_empty       (rsp_if.is_empty)
);

`default_nettype wire

// ----- tb/sv/positional_list_insert_delete_find_checker.sv -----
// Scoreboard for the positional list block: watches both channels, keeps its own
// copy of the list and compares every result transfer. Depends on plid_pkg.
`default_nettype none

module positional_list_insert_delete_find_checker
   import plid_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  wire [OP_W-1:0]          req_operation,
   input  wire [POS_W-1:0]         req_position,
   input  wire signed [DATA_W-1:0] req_value,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  wire [STAT_W-1:0]        rsp_status,
   input  wire [ADDR_W-1:0]        rsp_found_position,
   input  wire [CNT_W-1:0]         rsp_element_count,
   input  wire                     rsp_is_empty,
   output int                      failures,
   output int                      outstanding
);

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] hit_index;
      logic [CNT_W-1:0]  held_after;
      logic              empty;
   } list_outcome_type;

   logic signed [DATA_W-1:0] list_words [CAPACITY];
   int                       list_len;
   list_outcome_type         awaited_outcomes [$];
   int                       mismatch_count;

   assign failures = mismatch_count;

   initial begin
      list_len       = 0;
      mismatch_count = 0;
      outstanding    = 0;
   end

   // Applies one operation to the local list and returns the result it must give.
   function automatic list_outcome_type apply_operation(input op_type op,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [DATA_W-1:0] word);
      list_outcome_type res;
      int               k;
      bit               hit;
      res.status    = ST_OK;
      res.hit_index = '0;
      hit           = 1'b0;
      case (op)
         OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (int'(pos) > list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (k = list_len; k > int'(pos); k--) list_words[k] = list_words[k-1];
               list_words[pos] = word;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (int'(pos) >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (k = int'(pos) + 1; k < list_len; k++) list_words[k-1] = list_words[k];
               list_len--;
            end
         end
         OP_FIND: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status = ST_NOTFOUND;
               for (k = 0; k < list_len && !hit; k++) begin
                  if (list_words[k] == word) begin
                     hit           = 1'b1;
                     res.status    = ST_OK;
                     res.hit_index = ADDR_W'(k);
                  end
               end
            end
         end
         default: begin
            list_len = 0;
         end
      endcase
      res.held_after = CNT_W'(list_len);
      res.empty      = (list_len == 0);
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         list_len = 0;
         awaited_outcomes.delete();
      end else begin
         // A result is registered after its operation is taken, so the result
         // side is settled before this edge's operation is queued.
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected result transfer, status %0d, count %0d",
                        $time, rsp_status, rsp_element_count);
               mismatch_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("found_position", int'(want.hit_index), int'(rsp_found_position));
               check_field("element_count", int'(want.held_after), int'(rsp_element_count));
               check_field("is_empty", int'(want.empty), int'(rsp_is_empty));
            end
         end
         if (req_valid && req_ready) begin
            awaited_outcomes.push_back(apply_operation(op_type'(req_operation),
                                                       req_position, req_value));
         end
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

`default_nettype wire

// ----- tb/sv/positional_list_insert_delete_find_tb.sv -----
// Top of the positional list testbench: clock, reset, operation stimulus and the
// verdict. Depends on plid_pkg, the two channel interfaces, the block and the checker.
`default_nettype none

module positional_list_insert_delete_find_tb;
   import plid_pkg::*;

   // The random part stops issuing once this many operations have been sent.
   localparam int TARGET_OPS   = 1300;
   // Slowest operation is a find that walks the whole list.
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;

   plid_req_if req_if ();
   plid_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   int failures;
   int outstanding;
   int cycle_count = 0;

   positional_list_insert_delete_find u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   positional_list_insert_delete_find_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_operation      (req_if.operation),
      .req_position       (req_if.position),
      .req_value          (req_if.value),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_status         (rsp_if.status),
      .rsp_found_position (rsp_if.found_position),
      .rsp_element_count  (rsp_if.element_count),
      .rsp_is_empty       (rsp_if.is_empty),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Quiet flags switch off idling on one side for a whole episode, so that
   // back-to-back transfers are exercised as well as ragged ones.
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;

   // Result-side back-pressure. Ready is held for a random number of cycles,
   // mostly short, now and then a long stall.
   int unsigned ready_hold = 0;

   always @(posedge clock) begin
      int unsigned r;
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rx_quiet) begin
         sink_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 7);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            sink_ready <= 1'b1;
            ready_hold <= $urandom_range(0, 5);
         end else if (r < 90) begin
            sink_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
         end else begin
            sink_ready <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
         end
      end
   end

   // Stimulus-side bookkeeping. The length is tracked only so that most
   // positions land inside the list; the checker does the real prediction.
   // The word pool feeds finds with values that are actually held, and
   // inserts with repeats so that first-match ordering gets exercised.
   int                       shadow_len = 0;
   int                       issued     = 0;
   logic signed [DATA_W-1:0] word_pool [$];

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (tx_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45 && word_pool.size() != 0) return word_pool[$urandom_range(0, word_pool.size()-1)];
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // Sends one operation: an optional idle gap, then valid held until the
   // transfer happens. Valid is left high so the next operation can follow
   // back to back without a dead cycle.
   task automatic issue(input op_type op, input logic [POS_W-1:0] pos,
                        input logic signed [DATA_W-1:0] word);
      int unsigned idle;
      idle = pick_gap();
      if (idle != 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.position  <= pos;
      req_if.value     <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (op)
         OP_INSERT: begin
            if (shadow_len < CAPACITY && int'(pos) <= shadow_len) begin
               shadow_len++;
               word_pool.push_back(word);
               if (word_pool.size() > 12) void'(word_pool.pop_front());
            end
         end
         OP_DELETE: if (int'(pos) < shadow_len) shadow_len--;
         OP_CLEAR:  shadow_len = 0;
         default:   ;
      endcase
      issued++;
   endtask

   // One operation with random content. Most positions are legal for the
   // current length; the rest range over the whole six-bit field.
   task automatic issue_random();
      int unsigned      r;
      op_type           op;
      logic [POS_W-1:0] pos;
      r = $urandom_range(0, 99);
      if (r < 42)      op = OP_INSERT;
      else if (r < 66) op = OP_DELETE;
      else if (r < 98) op = OP_FIND;
      else             op = OP_CLEAR;
      pos = POS_W'($urandom_range(0, 63));
      if ($urandom_range(0, 9) < 8) begin
         if (op == OP_INSERT) pos = POS_W'($urandom_range(0, shadow_len));
         else if (shadow_len > 0) pos = POS_W'($urandom_range(0, shadow_len - 1));
      end
      issue(op, pos, pick_word());
   endtask

   // Fills the list to capacity from empty, then pokes at the full list:
   // inserts that must report full (one of them also out of range, since the
   // full check comes first), a find of the very last slot, and some deletes.
   task automatic fill_episode();
      logic signed [DATA_W-1:0] tail_word;
      issue(OP_CLEAR, POS_W'($urandom_range(0, 63)), $urandom);
      while (shadow_len < CAPACITY - 1) issue(OP_INSERT, POS_W'($urandom_range(0, shadow_len)),
                                              pick_word());
      tail_word = $urandom;
      issue(OP_INSERT, POS_W'(shadow_len), tail_word);
      issue(OP_INSERT, POS_W'($urandom_range(0, shadow_len)), pick_word());
      issue(OP_INSERT, POS_W'(63), pick_word());
      issue(OP_FIND, POS_W'($urandom_range(0, 63)), tail_word);
      repeat (3) issue(OP_FIND, POS_W'($urandom_range(0, 63)), pick_word());
      repeat ($urandom_range(1, 8)) issue(OP_DELETE, POS_W'($urandom_range(0, shadow_len - 1)),
                                          pick_word());
   endtask

   initial begin
      req_if.valid     = 1'b0;
      req_if.operation = OP_FIND;
      req_if.position  = '0;
      req_if.value     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: every operation on an empty list, the value
      // extremes, front, middle and end inserts, first-match and last-slot
      // finds, and out-of-range positions that set the top position bits.
      issue(OP_FIND,   6'd0,  32'sd5);
      issue(OP_DELETE, 6'd0,  32'sd0);
      issue(OP_INSERT, 6'd1,  32'sd7);
      issue(OP_CLEAR,  6'd0,  32'sd0);
      issue(OP_INSERT, 6'd0,  WORD_MIN);
      issue(OP_INSERT, 6'd1,  WORD_MAX);
      issue(OP_INSERT, 6'd0,  -32'sd1);
      issue(OP_INSERT, 6'd1,  32'sd0);
      issue(OP_INSERT, 6'd5,  32'sd9);
      issue(OP_FIND,   6'd0,  WORD_MAX);
      issue(OP_FIND,   6'd0,  -32'sd1);
      issue(OP_FIND,   6'd0,  32'sd12345);
      issue(OP_INSERT, 6'd4,  32'sd0);
      issue(OP_FIND,   6'd63, 32'sd0);
      issue(OP_DELETE, 6'd5,  32'sd0);
      issue(OP_DELETE, 6'd63, 32'sd0);
      issue(OP_DELETE, 6'd2,  32'sd0);
      issue(OP_DELETE, 6'd3,  32'sd0);
      issue(OP_DELETE, 6'd0,  32'sd0);
      issue(OP_INSERT, 6'd32, 32'sd3);
      issue(OP_CLEAR,  6'd0,  32'sd0);
      issue(OP_FIND,   6'd0,  32'sd0);

      // Random part: episodes of random operations with the occasional full
      // fill. The first episode is always a fill so capacity is reached early.
      fill_episode();
      while (issued < TARGET_OPS) begin
         tx_quiet = ($urandom_range(0, 5) == 0);
         rx_quiet = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0) fill_episode();
         else repeat ($urandom_range(20, 60)) issue_random();
      end
      req_if.valid <= 1'b0;

      // The outstanding count is registered, so let it take in the last
      // transfer before waiting for the results to drain.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
